[rtl/positional_char_list_longest_run_macros.svh]
// assertion macros shared by the symbol list rtl
`ifndef POSITIONAL_CHAR_LIST_LONGEST_RUN_MACROS_SVH
`define POSITIONAL_CHAR_LIST_LONGEST_RUN_MACROS_SVH

// property must hold at every edge outside reset
`define PLCLR_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("plclr check failed");

// condition must never be seen outside reset
`define PLCLR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("plclr forbidden condition");

`endif

[rtl/plclr_pkg.sv]
// types, codes and constants of the symbol list with longest-run report
package plclr_pkg;

  localparam int DEPTH_DEF = 64;
  // index width that covers every supported list depth
  localparam int IDX_W = 12;
  localparam int SYM_W = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [1:0] SIDE_NUM   = 2'd0;
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_BACK  = 2'd2;

  localparam logic [1:0] CM_HOLD = 2'd0;
  localparam logic [1:0] CM_INS  = 2'd1;
  localparam logic [1:0] CM_DEL  = 2'd2;
  localparam logic [1:0] CM_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [1:0]       side;
    logic [6:0]       position;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] run_symbol;
    logic [6:0]       run_length;
    logic             last;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] at;
    logic [SYM_W-1:0] sym;
  } cell_ctl_t;

endpackage

[rtl/positional_char_list_longest_run.sv]
// top level: symbol list held in a chain of cells, with edit decode and report walker
// Ordered list of up to DEPTH byte symbols. An item is taken when start is high and busy
// low. For insert and delete items every cell shifts in parallel, and an
// out-of-range or full/empty edit is dropped silently. A report on a list of N entries
// rotates the cell chain twice (one pass to find the longest run length and how many
// runs reach it, one pass to emit them), and busy stays high through both passes; each result
// is shown with strobe high for one cycle, in the cycle after the cell that ends its run
// passes the head, and the final one carries last. An empty list answers with one
// result (symbol 0, length 0, last) in the cycle after start, without raising busy. There
// is no backpressure: every strobe beat must be taken when it appears.
`include "positional_char_list_longest_run_macros.svh"
module positional_char_list_longest_run #(
  parameter int DEPTH = plclr_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  plclr_pkg::in_item_t   item,
  output logic                  strobe,
  output plclr_pkg::out_item_t  result
);
  import plclr_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

  logic [CW-1:0]    cnt, cnt_next;
  cell_ctl_t        ctl;
  logic             report_go, ok;
  logic [CMPW-1:0]  pos_e, cnt_e, at_v;
  logic [SYM_W-1:0] q [DEPTH];

  always_comb begin
    ctl.mode  = CM_HOLD;
    ctl.at    = '0;
    ctl.sym   = item.symbol;
    cnt_next  = cnt;
    report_go = 1'b0;
    ok        = 1'b0;
    at_v      = '0;
    pos_e     = CMPW'(item.position);
    cnt_e     = CMPW'(cnt);
    if (busy) begin
      ctl.mode = CM_ROT;
      ctl.at   = IDX_W'(cnt - CW'(1));
    end else if (start) begin
      unique case (item.opcode)
        OP_INSERT: begin
          if (cnt != CW'(DEPTH)) begin
            case (item.side)
              SIDE_FRONT: begin
                ok = 1'b1;
              end
              SIDE_BACK: begin
                ok   = 1'b1;
                at_v = cnt_e;
              end
              SIDE_NUM: begin
                ok   = (pos_e != '0) && (pos_e <= cnt_e + CMPW'(1));
                at_v = pos_e - CMPW'(1);
              end
              default: begin
                ok = 1'b0;
              end
            endcase
          end
          if (ok) begin
            ctl.mode = CM_INS;
            ctl.at   = IDX_W'(at_v);
            cnt_next = cnt + CW'(1);
          end
        end
        OP_DELETE: begin
          if (cnt != '0) begin
            case (item.side)
              SIDE_FRONT: begin
                ok = 1'b1;
              end
              SIDE_BACK: begin
                ok   = 1'b1;
                at_v = cnt_e - CMPW'(1);
              end
              SIDE_NUM: begin
                ok   = (pos_e != '0) && (pos_e <= cnt_e);
                at_v = pos_e - CMPW'(1);
              end
              default: begin
                ok = 1'b0;
              end
            endcase
          end
          if (ok) begin
            ctl.mode = CM_DEL;
            ctl.at   = IDX_W'(at_v);
            cnt_next = cnt - CW'(1);
          end
        end
        OP_REPORT: begin
          report_go = 1'b1;
        end
        default: begin
          report_go = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SYM_W-1:0] left_sym, right_sym;
    if (i == 0) begin : g_first
      assign left_sym = item.symbol;
    end else begin : g_mid
      assign left_sym = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_sym = q[i];
    end else begin : g_body
      assign right_sym = q[i+1];
    end
    plclr_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left (left_sym),
      .right(right_sym),
      .head (q[0]),
      .q    (q[i])
    );
  end

  plclr_scan #(
    .DEPTH(DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .go    (report_go),
    .cnt   (cnt),
    .head  (q[0]),
    .busy  (busy),
    .strobe(strobe),
    .result(result)
  );

  `PLCLR_CHECK(a_cnt_range, cnt <= CW'(DEPTH))
  // the fill count is frozen while the report walks the chain
  `PLCLR_CHECK(a_cnt_frozen, busy |=> (cnt == $past(cnt)))
  `PLCLR_NEVER(a_edit_when_busy, busy && (ctl.mode == CM_INS || ctl.mode == CM_DEL))

endmodule

[rtl/plclr_cell.sv]
// one list cell: holds a symbol and moves it to or from its neighbors
module plclr_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  plclr_pkg::cell_ctl_t        ctl,
  input  logic [plclr_pkg::SYM_W-1:0] left,
  input  logic [plclr_pkg::SYM_W-1:0] right,
  input  logic [plclr_pkg::SYM_W-1:0] head,
  output logic [plclr_pkg::SYM_W-1:0] q
);
  import plclr_pkg::*;

  logic [IDX_W-1:0] me;
  assign me = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    case (ctl.mode)
      CM_INS: begin
        if (me > ctl.at) begin
          q <= left;
        end else if (me == ctl.at) begin
          q <= ctl.sym;
        end
      end
      CM_DEL: begin
        if (me >= ctl.at) begin
          q <= right;
        end
      end
      // rotate the held entries by one toward the head, at marks the tail
      CM_ROT: begin
        if (me == ctl.at) begin
          q <= head;
        end else if (me < ctl.at) begin
          q <= right;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

[rtl/plclr_scan.sv]
// report walker: two passes over the rotating list, finds and emits longest runs
`include "positional_char_list_longest_run_macros.svh"
module plclr_scan #(
  parameter int DEPTH = plclr_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [$clog2(DEPTH+1)-1:0]     cnt,
  input  logic [plclr_pkg::SYM_W-1:0]    head,
  output logic                           busy,
  output logic                           strobe,
  output plclr_pkg::out_item_t           result
);
  import plclr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PASS1 = 2'd1;
  localparam logic [1:0] S_PASS2 = 2'd2;

  logic [1:0]       state;
  logic [AW-1:0]    k;
  logic [CW-1:0]    run, best, nbest, emitted;
  logic [SYM_W-1:0] prev;
  logic [CW-1:0]    run_next;
  logic             same, last_k, emit_now;

  always_comb begin
    same     = (k != '0) && (head == prev);
    run_next = same ? run + CW'(1) : CW'(1);
    last_k   = (k == AW'(cnt - CW'(1)));
    emit_now = (state == S_PASS2) && (run_next == best);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            if (cnt == '0) begin
              strobe            <= 1'b1;
              result.run_symbol <= '0;
              result.run_length <= '0;
              result.last       <= 1'b1;
            end else begin
              state <= S_PASS1;
              k     <= '0;
              best  <= '0;
              nbest <= '0;
            end
          end
        end
        S_PASS1: begin
          prev <= head;
          run  <= run_next;
          k    <= k + AW'(1);
          if (run_next > best) begin
            best  <= run_next;
            nbest <= CW'(1);
          end else if (run_next == best) begin
            nbest <= nbest + CW'(1);
          end
          if (last_k) begin
            state   <= S_PASS2;
            k       <= '0;
            emitted <= '0;
          end
        end
        S_PASS2: begin
          prev <= head;
          run  <= run_next;
          k    <= k + AW'(1);
          if (emit_now) begin
            strobe            <= 1'b1;
            result.run_symbol <= head;
            result.run_length <= 7'(best);
            result.last       <= (emitted + CW'(1) == nbest);
            emitted           <= emitted + CW'(1);
          end
          if (last_k) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // every counted longest run is emitted by the end of the second pass
  `PLCLR_CHECK(a_all_emitted,
    (state == S_PASS2 && last_k) |-> (emitted + CW'(emit_now) == nbest))
  `PLCLR_CHECK(a_best_fits, (state == S_PASS2) |-> (best <= cnt && best != '0))
  // a result that is not the last one leaves the walker still running
  `PLCLR_NEVER(a_early_end, strobe && !result.last && !busy)

endmodule

[tb/sv/positional_char_list_longest_run_tb.sv]
// self-checking testbench for the symbol list with longest-run report
`timescale 1ns / 100ps
module positional_char_list_longest_run_tb;
  import plclr_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int SETTLE      = 2 * LIST_DEPTH + 8;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_BEATS = 30;

  // codes the block must ignore
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] SIDE_UNUSED = 2'd3;

  typedef struct packed {
    logic     drain;
    in_item_t beat;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  item = '0;
  logic      busy;
  logic      strobe;
  out_item_t result;

  positional_char_list_longest_run dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always #6 clk = ~clk;

  stim_t     pending[$];
  out_item_t expected_runs[$];

  // predicted list contents
  logic [7:0] sym_list [LIST_DEPTH];
  int         list_len = 0;
  int         gen_len = 0;

  int  mismatches = 0;
  int  items_taken = 0;
  int  reports_taken = 0;
  int  runs_checked = 0;
  int  longest_list = 0;
  int  drain_waits = 0;
  int  stall_cycles = 0;
  int  hold_off = 0;
  bit  burst = 1'b0;
  bit  presenting = 1'b0;

  // apply one accepted beat to the predicted list, queue any run results
  task automatic track_list_item(input in_item_t it);
    int        at;
    int        best;
    int        run;
    int        ties;
    int        k;
    bit        ok;
    out_item_t r;
    ok = 1'b0;
    at = 0;
    case (it.opcode)
      OP_INSERT: begin
        if (list_len < LIST_DEPTH) begin
          if (it.side == SIDE_FRONT) begin
            at = 0;
            ok = 1'b1;
          end else if (it.side == SIDE_BACK) begin
            at = list_len;
            ok = 1'b1;
          end else if (it.side == SIDE_NUM && it.position != 0 &&
                       it.position <= list_len + 1) begin
            at = it.position - 1;
            ok = 1'b1;
          end
        end
        if (ok) begin
          for (int i = list_len; i > at; i--) sym_list[i] = sym_list[i-1];
          sym_list[at] = it.symbol;
          list_len++;
          if (list_len > longest_list) longest_list = list_len;
        end
      end
      OP_DELETE: begin
        if (list_len > 0) begin
          if (it.side == SIDE_FRONT) begin
            at = 0;
            ok = 1'b1;
          end else if (it.side == SIDE_BACK) begin
            at = list_len - 1;
            ok = 1'b1;
          end else if (it.side == SIDE_NUM && it.position != 0 &&
                       it.position <= list_len) begin
            at = it.position - 1;
            ok = 1'b1;
          end
        end
        if (ok) begin
          for (int i = at; i + 1 < list_len; i++) sym_list[i] = sym_list[i+1];
          list_len--;
        end
      end
      OP_REPORT: begin
        reports_taken++;
        if (list_len == 0) begin
          r.run_symbol = '0;
          r.run_length = '0;
          r.last = 1'b1;
          expected_runs.push_back(r);
        end else begin
          best = 0;
          ties = 0;
          run = 0;
          for (int i = 0; i < list_len; i++) begin
            run = (i > 0 && sym_list[i] == sym_list[i-1]) ? run + 1 : 1;
            if (run > best) begin
              best = run;
              ties = 1;
            end else if (run == best) begin
              ties++;
            end
          end
          k = 0;
          run = 0;
          for (int i = 0; i < list_len; i++) begin
            run = (i > 0 && sym_list[i] == sym_list[i-1]) ? run + 1 : 1;
            if (run == best) begin
              k++;
              r.run_symbol = sym_list[i];
              r.run_length = 7'(best);
              r.last = (k == ties);
              expected_runs.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // list length after a beat, so the stimulus can aim positions in range
  function automatic int len_after(input in_item_t it, input int n);
    if (it.opcode == OP_INSERT && n < LIST_DEPTH &&
        (it.side == SIDE_FRONT || it.side == SIDE_BACK ||
         (it.side == SIDE_NUM && it.position != 0 && it.position <= n + 1)))
      return n + 1;
    if (it.opcode == OP_DELETE && n > 0 &&
        (it.side == SIDE_FRONT || it.side == SIDE_BACK ||
         (it.side == SIDE_NUM && it.position != 0 && it.position <= n)))
      return n - 1;
    return n;
  endfunction

  task automatic plan_beat(input logic [1:0] op, input logic [1:0] sd,
                           input logic [6:0] pos, input logic [7:0] sym,
                           input bit drain);
    stim_t s;
    s.drain = drain;
    s.beat.opcode = op;
    s.beat.side = sd;
    s.beat.position = pos;
    s.beat.symbol = sym;
    gen_len = len_after(s.beat, gen_len);
    pending.push_back(s);
  endtask

  // small alphabet most of the time so equal neighbors form runs
  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 99) < 70) return 8'(8'h30 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic plan_random_beat();
    int         roll;
    int         ins_cut;
    logic [1:0] sd;
    logic [6:0] pos;
    bit         drain;
    roll = $urandom_range(0, 99);
    ins_cut = (gen_len < 12) ? 62 : 45;
    sd = 2'($urandom_range(0, 2));
    drain = ($urandom_range(0, 19) == 0);
    if (roll < 8) begin
      plan_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), drain);
    end else if (roll < 22) begin
      plan_beat(OP_REPORT, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)), drain);
    end else if (roll < ins_cut) begin
      pos = (sd == SIDE_NUM) ? 7'($urandom_range(1, gen_len + 1))
                             : 7'($urandom_range(0, 127));
      plan_beat(OP_INSERT, sd, pos, pick_symbol(), drain);
    end else begin
      pos = (sd == SIDE_NUM) ? 7'($urandom_range(1, gen_len)) : 7'($urandom_range(0, 127));
      plan_beat(OP_DELETE, sd, pos, 8'($urandom_range(0, 255)), drain);
    end
  endtask

  // grow the list to full with mostly distinct symbols, report, then empty it
  task automatic plan_fill_and_drain();
    logic [1:0] sd;
    plan_beat(OP_REPORT, SIDE_NUM, 7'd0, 8'h00, 1'b1);
    while (gen_len < LIST_DEPTH) begin
      sd = 2'($urandom_range(0, 2));
      plan_beat(OP_INSERT, sd, 7'($urandom_range(1, gen_len + 1)),
                8'($urandom_range(0, 255)), 1'b0);
    end
    plan_beat(OP_INSERT, SIDE_BACK, 7'd0, 8'hA5, 1'b0);
    plan_beat(OP_INSERT, SIDE_NUM, 7'd1, 8'h5A, 1'b0);
    plan_beat(OP_REPORT, SIDE_NUM, 7'd0, 8'h00, 1'b1);
    while (gen_len > 0) begin
      sd = 2'($urandom_range(0, 2));
      plan_beat(OP_DELETE, sd, 7'($urandom_range(1, gen_len)), 8'h00, 1'b0);
      if ($urandom_range(0, 15) == 0) plan_beat(OP_REPORT, SIDE_NUM, 7'd0, 8'h00, 1'b0);
    end
    plan_beat(OP_REPORT, SIDE_BACK, 7'd0, 8'h00, 1'b0);
  endtask

  initial begin
    // empty list: report and edits that must be dropped, then inserts that build a list and a report
    plan_beat(OP_REPORT, SIDE_NUM, 7'd0, 8'h00, 1'b0);
    plan_beat(OP_DELETE, SIDE_FRONT, 7'd0, 8'h00, 1'b0);
    plan_beat(OP_DELETE, SIDE_BACK, 7'd0, 8'h00, 1'b0);
    plan_beat(OP_DELETE, SIDE_NUM, 7'd1, 8'h00, 1'b0);
    plan_beat(OP_INSERT, SIDE_NUM, 7'd0, 8'h11, 1'b0);
    plan_beat(OP_INSERT, SIDE_NUM, 7'd2, 8'h22, 1'b0);
    plan_beat(OP_INSERT, SIDE_NUM, 7'd1, 8'h00, 1'b0);
    plan_beat(OP_INSERT, SIDE_FRONT, 7'd0, 8'hFF, 1'b0);
    plan_beat(OP_INSERT, SIDE_BACK, 7'd0, 8'hFF, 1'b0);
    plan_beat(OP_INSERT, SIDE_NUM, 7'd2, 8'hFF, 1'b0);
    plan_beat(OP_REPORT, SIDE_NUM, 7'd0, 8'h00, 1'b0);
    // unused side and opcode codes, then out-of-range and valid edits
    plan_beat(OP_INSERT, SIDE_UNUSED, 7'd1, 8'h77, 1'b0);
    plan_beat(OP_UNUSED, SIDE_FRONT, 7'd1, 8'h77, 1'b0);
    plan_beat(OP_DELETE, SIDE_UNUSED, 7'd1, 8'h00, 1'b0);
    plan_beat(OP_DELETE, SIDE_NUM, 7'd0, 8'h00, 1'b0);
    plan_beat(OP_DELETE, SIDE_NUM, 7'd5, 8'h00, 1'b0);
    plan_beat(OP_DELETE, SIDE_NUM, 7'd3, 8'h00, 1'b0);
    plan_beat(OP_REPORT, SIDE_NUM, 7'd0, 8'h00, 1'b0);
    plan_beat(OP_INSERT, SIDE_NUM, 7'd4, 8'h55, 1'b0);
    plan_beat(OP_INSERT, SIDE_NUM, 7'd127, 8'h55, 1'b0);
    plan_beat(OP_INSERT, SIDE_BACK, 7'd127, 8'h55, 1'b0);
    plan_beat(OP_DELETE, SIDE_NUM, 7'd1, 8'h00, 1'b0);
    // two runs tie for longest
    plan_beat(OP_REPORT, SIDE_NUM, 7'd0, 8'h00, 1'b1);
    plan_beat(OP_DELETE, SIDE_BACK, 7'd0, 8'h00, 1'b0);
    plan_beat(OP_REPORT, SIDE_FRONT, 7'd0, 8'h00, 1'b0);

    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k == RANDOM_BEATS / 3) plan_fill_and_drain();
      plan_random_beat();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start || presenting) @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (expected_runs.size() != 0) begin
      $error("results never seen: expected %0d more, got 0", expected_runs.size());
      mismatches++;
    end

    $display("covered %0d beats, %0d reports, %0d run results checked", items_taken,
             reports_taken, runs_checked);
    $display("list reached %0d entries, sender drained the block %0d times", longest_list,
             drain_waits);
    if (mismatches == 0) begin
      $display("positional_char_list_longest_run test passed");
    end else begin
      $display("positional_char_list_longest_run test failed");
    end
    $finish;
  end

  // driver: one beat at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      hold_off = 0;
    end else begin
      presenting = start;
      if (start && !busy) begin
        track_list_item(item);
        items_taken++;
        presenting = 1'b0;
      end
      if (!presenting && pending.size() != 0) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (!pending[0].drain || (expected_runs.size() == 0 && !strobe)) begin
          item <= pending[0].beat;
          if (pending[0].drain) drain_waits++;
          pending.delete(0);
          presenting = 1'b1;
          if ($urandom_range(0, 14) == 0) burst = !burst;
          hold_off = burst ? 0 : $urandom_range(0, 6);
        end
      end
      start <= presenting;
    end
  end

  // monitor: every strobe beat is checked against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected result: run_symbol %0d run_length %0d last %0d",
               result.run_symbol, result.run_length, result.last);
        mismatches++;
      end else begin
        want = expected_runs.pop_front();
        runs_checked++;
        if (result.run_symbol !== want.run_symbol) begin
          $error("run_symbol: expected %0d, got %0d", want.run_symbol, result.run_symbol);
          mismatches++;
        end
        if (result.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, result.run_length);
          mismatches++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where no beat moves either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("positional_char_list_longest_run test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/plclr_pkg.sv
rtl/plclr_cell.sv
rtl/plclr_scan.sv
rtl/positional_char_list_longest_run.sv
tb/sv/positional_char_list_longest_run_tb.sv
